// ===== sv/matrix_multiply_fp32_assert.svh =====
// Assertion macros shared by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_FP32_ASSERT_SVH
`define MATRIX_MULTIPLY_FP32_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MMF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix multiply check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MMF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix multiply check failed");

`endif

// ===== sv/mmf_pkg.sv =====
// Types and constants shared by the matrix multiply modules.
package mmf_pkg;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_CVT
  } fop_t;

  typedef struct packed {
    logic       start;
    fop_t       op;
    logic [1:0] fmt;
  } fpu_req_t;

  localparam logic [1:0] FMT_FP32  = 2'd0;
  localparam logic [1:0] FMT_FP16  = 2'd1;
  localparam logic [1:0] FMT_BF16  = 2'd2;
  localparam logic [1:0] FMT_INT32 = 2'd3;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [2:0] REG_ROWS_A   = 3'd0;
  localparam logic [2:0] REG_INNER    = 3'd1;
  localparam logic [2:0] REG_COLS_B   = 3'd2;
  localparam logic [2:0] REG_A_FORMAT = 3'd3;
  localparam logic [2:0] REG_B_FORMAT = 3'd4;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;

endpackage

// ===== sv/mmf_ram.sv =====
// Simple dual-port element store with registered read data.
module mmf_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mmf_fpu.sv =====
// Shared multi-cycle fp32 unit: multiply, add and format conversion with
// round to nearest-even, subnormals and a stepped normalizing shifter.
module mmf_fpu (
  input  logic              clk,
  input  logic              rst,
  input  mmf_pkg::fpu_req_t req,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       result
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ALIGN,
    F_SUM,
    F_DENORM,
    F_NORM,
    F_ROUND
  } fstate_t;

  fstate_t            state;
  logic               sgn;
  logic signed [10:0] ex;
  logic [47:0]        man;
  logic [47:0]        sm;
  logic [23:0]        ma, mb;
  logic [7:0]         dshift;
  logic               sub;
  logic [2:0]         step;

  // Operand classification.
  logic [7:0]  ea, eb, eae, ebe;
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [23:0] fa, fb;
  logic        a_big;
  logic        psgn;

  assign ea     = a[30:23];
  assign eb     = b[30:23];
  assign eae    = (ea == 8'd0) ? 8'd1 : ea;
  assign ebe    = (eb == 8'd0) ? 8'd1 : eb;
  assign fa     = {ea != 8'd0, a[22:0]};
  assign fb     = {eb != 8'd0, b[22:0]};
  assign a_zero = (a[30:0] == 31'd0);
  assign b_zero = (b[30:0] == 31'd0);
  assign a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
  assign b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
  assign a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
  assign b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
  assign a_big  = (a[30:0] >= b[30:0]);
  assign psgn   = a[31] ^ b[31];

  // Half and 16-bit brain-float fields.
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [31:0] bf;
  logic [31:0] mag;
  assign he  = a[14:10];
  assign hm  = a[9:0];
  assign bf  = {a[15:0], 16'd0};
  assign mag = a[31] ? (~a + 32'd1) : a;

  // Right shift with sticky, used for alignment and denormalization.
  logic [47:0] align_out;
  logic        align_lost;
  logic [10:0] den_amt;
  logic [47:0] den_out;
  logic        den_lost;
  assign align_out  = sm >> dshift;
  assign align_lost = ((align_out << dshift) != sm);
  assign den_amt    = 11'(11'sd1 - ex);
  assign den_out    = man >> den_amt;
  assign den_lost   = ((den_out << den_amt) != man);

  // One binary step of the normalizing shift.
  logic [5:0] amt;
  logic       norm_ok;
  assign amt     = 6'd32 >> step;
  assign norm_ok = ((man >> (6'd48 - amt)) == 48'd0) && (ex > $signed({5'd0, amt}));

  // Rounding.
  logic [23:0]        kept;
  logic               rup;
  logic [24:0]        rnd;
  logic signed [10:0] ef;
  logic [22:0]        frac;
  assign kept = man[47:24];
  assign rup  = man[23] && ((man[22:0] != 23'd0) || kept[0]);
  assign rnd  = {1'b0, kept} + {24'd0, rup};
  assign ef   = rnd[24] ? (ex + 11'sd1) : (rnd[23] ? ex : 11'sd0);
  assign frac = rnd[24] ? rnd[23:1] : rnd[22:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      done   <= 1'b0;
      result <= mmf_pkg::FP_ZERO;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            unique case (req.op)
              mmf_pkg::FOP_MUL: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                  result <= mmf_pkg::FP_QNAN;
                  done   <= 1'b1;
                end else if (a_inf || b_inf) begin
                  result <= {psgn, 8'hFF, 23'd0};
                  done   <= 1'b1;
                end else if (a_zero || b_zero) begin
                  result <= {psgn, 31'd0};
                  done   <= 1'b1;
                end else begin
                  ma    <= fa;
                  mb    <= fb;
                  sgn   <= psgn;
                  ex    <= $signed({3'd0, eae}) + $signed({3'd0, ebe}) - 11'sd126;
                  state <= F_MUL;
                end
              end
              mmf_pkg::FOP_ADD: begin
                if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
                  result <= mmf_pkg::FP_QNAN;
                  done   <= 1'b1;
                end else if (a_inf) begin
                  result <= a;
                  done   <= 1'b1;
                end else if (b_inf) begin
                  result <= b;
                  done   <= 1'b1;
                end else if (a_zero && b_zero) begin
                  result <= {a[31] & b[31], 31'd0};
                  done   <= 1'b1;
                end else if (a_zero) begin
                  result <= b;
                  done   <= 1'b1;
                end else if (b_zero) begin
                  result <= a;
                  done   <= 1'b1;
                end else begin
                  sgn    <= a_big ? a[31] : b[31];
                  ex     <= $signed({3'd0, (a_big ? eae : ebe)}) + 11'sd1;
                  man    <= {1'b0, (a_big ? fa : fb), 23'd0};
                  sm     <= {1'b0, (a_big ? fb : fa), 23'd0};
                  dshift <= a_big ? (eae - ebe) : (ebe - eae);
                  sub    <= a[31] ^ b[31];
                  state  <= F_ALIGN;
                end
              end
              mmf_pkg::FOP_CVT: begin
                case (req.fmt)
                  mmf_pkg::FMT_FP16: begin
                    if ((he == 5'd0) && (hm == 10'd0)) begin
                      result <= {a[15], 31'd0};
                      done   <= 1'b1;
                    end else if (he == 5'h1F) begin
                      result <= {a[15], 8'hFF, hm, 13'd0} |
                                ((hm != 10'd0) ? 32'h0040_0000 : 32'd0);
                      done   <= 1'b1;
                    end else begin
                      sgn   <= a[15];
                      man   <= {he != 5'd0, hm, 37'd0};
                      ex    <= $signed({6'd0, ((he == 5'd0) ? 5'd1 : he)}) + 11'sd112;
                      state <= F_DENORM;
                    end
                  end
                  mmf_pkg::FMT_BF16: begin
                    if ((bf[30:23] == 8'hFF) && (bf[22:0] != 23'd0)) begin
                      result <= bf | 32'h0040_0000;
                    end else begin
                      result <= bf;
                    end
                    done <= 1'b1;
                  end
                  mmf_pkg::FMT_INT32: begin
                    if (a == 32'd0) begin
                      result <= mmf_pkg::FP_ZERO;
                      done   <= 1'b1;
                    end else begin
                      sgn   <= a[31];
                      man   <= {mag, 16'd0};
                      ex    <= 11'sd158;
                      state <= F_DENORM;
                    end
                  end
                  default: begin
                    result <= a;
                    done   <= 1'b1;
                  end
                endcase
              end
              default: begin
                result <= mmf_pkg::FP_ZERO;
                done   <= 1'b1;
              end
            endcase
          end
        end
        F_MUL: begin
          man   <= ma * mb;
          state <= F_DENORM;
        end
        F_ALIGN: begin
          sm    <= align_out | {47'd0, align_lost};
          state <= F_SUM;
        end
        F_SUM: begin
          man <= sub ? (man - sm) : (man + sm);
          // An exact cancellation rounds to +0.
          if (sub && (man == sm)) begin
            sgn <= 1'b0;
          end
          state <= F_DENORM;
        end
        F_DENORM: begin
          if (ex < 11'sd1) begin
            man <= den_out | {47'd0, den_lost};
            ex  <= 11'sd1;
          end
          step  <= 3'd0;
          state <= F_NORM;
        end
        F_NORM: begin
          if (norm_ok) begin
            man <= man << amt;
            ex  <= ex - $signed({5'd0, amt});
          end
          step <= step + 3'd1;
          if (step == 3'd5) begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          if (ef >= 11'sd255) begin
            result <= {sgn, 8'hFF, 23'd0};
          end else begin
            result <= {sgn, ef[7:0], frac};
          end
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/matrix_multiply_fp32.sv =====
// Top level of the fp32 matrix multiplier: register port, sequencer, stores.
//
// The block loads matrix A and matrix B one element per transfer on the
// input stream (s_tuser selects load A, load B or read), converts each element
// to fp32 and keeps it in an on-chip store of MAX_DIM*MAX_DIM words per
// matrix. Each read transfer returns the next row-major element of A*B on the
// output stream, a dot product accumulated from the first term upward with a
// separately rounded multiply and add per term. A read while a matrix is still
// incomplete, or after the whole product was read, returns status 1 with a
// zero value. The final element carries tlast and restarts both loads. The
// block takes one transfer at a time: an fp32 or bf16 load converts directly,
// an fp16 or int32 load normalizes and rounds, a read with no product element
// needs no arithmetic, and a valid read does the row and column split and the
// setup, then a fetch, a multiply and an add per term, the last two sooner for
// a zero or non-finite operand. All of this is set by the single shared
// floating-point unit that does every multiply, add and conversion. A result
// waits in the output register while the next transfer is already taken, and
// a finished result that finds the output register still full holds the
// sequencer until it drains. The stores are not cleared at reset.
module matrix_multiply_fp32 #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element
  input  logic [1:0]  s_tuser,   // [1:0] action
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // [0] status
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_RAW = $clog2(DEPTH + 1);
  localparam int CNT_W   = (CNT_RAW < 2) ? 2 : CNT_RAW;
  localparam int DIV_W   = $clog2(CNT_W);
  localparam logic [4:0] DIM_CAP = (MAX_DIM > 31) ? 5'd31 : 5'(MAX_DIM);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CVT,
    S_DIV,
    S_BASE,
    S_FETCH,
    S_MULGO,
    S_MUL,
    S_ADD,
    S_STAT
  } state_t;

  // Configuration registers.
  logic [4:0] rows_a, inner_len, cols_b;
  logic [1:0] a_format, b_format;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= 5'd16;
      inner_len <= 5'd16;
      cols_b    <= 5'd16;
      a_format  <= mmf_pkg::FMT_FP32;
      b_format  <= mmf_pkg::FMT_FP32;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        mmf_pkg::REG_ROWS_A:   rows_a    <= pwdata[4:0];
        mmf_pkg::REG_INNER:    inner_len <= pwdata[4:0];
        mmf_pkg::REG_COLS_B:   cols_b    <= pwdata[4:0];
        mmf_pkg::REG_A_FORMAT: a_format  <= pwdata[1:0];
        mmf_pkg::REG_B_FORMAT: b_format  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mmf_pkg::REG_ROWS_A:   prdata = {27'd0, rows_a};
      mmf_pkg::REG_INNER:    prdata = {27'd0, inner_len};
      mmf_pkg::REG_COLS_B:   prdata = {27'd0, cols_b};
      mmf_pkg::REG_A_FORMAT: prdata = {30'd0, a_format};
      mmf_pkg::REG_B_FORMAT: prdata = {30'd0, b_format};
      default:               prdata = 32'd0;
    endcase
  end

  // Effective dimensions: zero acts as one, anything above the store size
  // acts as MAX_DIM.
  logic [4:0]  dim_m, dim_k, dim_n;
  logic [9:0]  size_a, size_b, size_c;
  assign dim_m  = (rows_a == 5'd0) ? 5'd1 : ((32'(rows_a) > MAX_DIM) ? DIM_CAP : rows_a);
  assign dim_k  = (inner_len == 5'd0) ? 5'd1 :
                  ((32'(inner_len) > MAX_DIM) ? DIM_CAP : inner_len);
  assign dim_n  = (cols_b == 5'd0) ? 5'd1 : ((32'(cols_b) > MAX_DIM) ? DIM_CAP : cols_b);
  assign size_a = dim_m * dim_k;
  assign size_b = dim_k * dim_n;
  assign size_c = dim_m * dim_n;

  // Sequencer state.
  state_t             state;
  logic               load_a;
  logic [CNT_W-1:0]   a_loaded, b_loaded, out_position;
  logic [CNT_W-1:0]   div_q;
  logic [4:0]         div_r;
  logic [DIV_W-1:0]   div_cnt;
  logic [ADDR_W-1:0]  a_ptr, b_ptr;
  logic [4:0]         term;
  logic [31:0]        sum;
  logic [31:0]        op_a, op_b;
  mmf_pkg::fpu_req_t  fpu_req;
  logic               fpu_done;
  logic [31:0]        fpu_result;
  logic [31:0]        ram_a_rdata, ram_b_rdata;
  logic               ram_a_we, ram_b_we;

  logic               in_xfer, out_free, a_full, b_full, a_room, b_room;
  logic [5:0]         div_trial;
  logic               div_bit;
  logic [CNT_W-1:0]   pos_inc;
  logic               final_read;
  logic               out_load;
  logic [CNT_W+4:0]   row_base;

  assign s_tready   = (state == S_IDLE);
  assign in_xfer    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign a_full     = (16'(a_loaded) >= 16'(size_a));
  assign b_full     = (16'(b_loaded) >= 16'(size_b));
  assign a_room     = !a_full && (a_loaded < DEPTH_C);
  assign b_room     = !b_full && (b_loaded < DEPTH_C);
  assign div_trial  = {div_r, div_q[CNT_W-1]};
  assign div_bit    = (div_trial >= {1'b0, dim_n});
  assign pos_inc    = out_position + CNT_W'(1);
  assign final_read = (16'(pos_inc) >= 16'(size_c));
  assign row_base   = div_q * dim_k;
  // A finished dot product goes to the output register once it is free.
  assign out_load   = (state == S_ADD) && fpu_done && (term == dim_k - 5'd1) && out_free;

  assign ram_a_we = (state == S_CVT) && fpu_done && load_a;
  assign ram_b_we = (state == S_CVT) && fpu_done && !load_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      a_loaded     <= '0;
      b_loaded     <= '0;
      out_position <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= mmf_pkg::FP_ZERO;
      m_tlast      <= 1'b0;
      m_tuser      <= 1'b0;
      fpu_req      <= '{start: 1'b0, op: mmf_pkg::FOP_CVT, fmt: mmf_pkg::FMT_FP32};
    end else begin
      fpu_req.start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (s_tuser)
              mmf_pkg::ACT_LOAD_A: begin
                if (a_room) begin
                  load_a  <= 1'b1;
                  op_a    <= s_tdata;
                  fpu_req <= '{start: 1'b1, op: mmf_pkg::FOP_CVT, fmt: a_format};
                  state   <= S_CVT;
                end
              end
              mmf_pkg::ACT_LOAD_B: begin
                if (b_room) begin
                  load_a  <= 1'b0;
                  op_a    <= s_tdata;
                  fpu_req <= '{start: 1'b1, op: mmf_pkg::FOP_CVT, fmt: b_format};
                  state   <= S_CVT;
                end
              end
              mmf_pkg::ACT_READ: begin
                if (!a_full || !b_full || (16'(out_position) >= 16'(size_c))) begin
                  // No product element available: reply at once when the
                  // output register is free, else wait for it to drain.
                  if (out_free) begin
                    m_tvalid <= 1'b1;
                    m_tdata  <= mmf_pkg::FP_ZERO;
                    m_tlast  <= 1'b0;
                    m_tuser  <= 1'b1;
                  end else begin
                    state <= S_STAT;
                  end
                end else begin
                  div_q   <= out_position;
                  div_r   <= 5'd0;
                  div_cnt <= '0;
                  state   <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_CVT: begin
          if (fpu_done) begin
            if (load_a) begin
              a_loaded <= a_loaded + CNT_W'(1);
            end else begin
              b_loaded <= b_loaded + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle: row and column of the next element.
          div_r   <= div_bit ? 5'(div_trial - {1'b0, dim_n}) : div_trial[4:0];
          div_q   <= {div_q[CNT_W-2:0], div_bit};
          div_cnt <= div_cnt + DIV_W'(1);
          if (32'(div_cnt) == CNT_W - 1) begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          a_ptr <= row_base[ADDR_W-1:0];
          b_ptr <= ADDR_W'(div_r);
          term  <= 5'd0;
          sum   <= mmf_pkg::FP_ZERO;
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_MULGO;
        end
        S_MULGO: begin
          op_a    <= ram_a_rdata;
          op_b    <= ram_b_rdata;
          fpu_req <= '{start: 1'b1, op: mmf_pkg::FOP_MUL, fmt: mmf_pkg::FMT_FP32};
          state   <= S_MUL;
        end
        S_MUL: begin
          if (fpu_done) begin
            op_a    <= sum;
            op_b    <= fpu_result;
            fpu_req <= '{start: 1'b1, op: mmf_pkg::FOP_ADD, fmt: mmf_pkg::FMT_FP32};
            state   <= S_ADD;
          end
        end
        S_ADD: begin
          if (fpu_done || (term == dim_k - 5'd1 && fpu_req.op == mmf_pkg::FOP_MUL)) begin
            if (fpu_done) begin
              sum <= fpu_result;
            end
            if (term != dim_k - 5'd1) begin
              term  <= term + 5'd1;
              a_ptr <= a_ptr + ADDR_W'(1);
              b_ptr <= b_ptr + ADDR_W'(dim_n);
              state <= S_FETCH;
            end else if (out_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= fpu_done ? fpu_result : sum;
              m_tlast  <= final_read;
              m_tuser  <= 1'b0;
              if (final_read) begin
                a_loaded     <= '0;
                b_loaded     <= '0;
                out_position <= '0;
              end else begin
                out_position <= pos_inc;
              end
              state <= S_IDLE;
            end else begin
              // Hold the finished sum until the output register is free.
              fpu_req.op <= mmf_pkg::FOP_MUL;
            end
          end
        end
        S_STAT: begin
          // A status-only reply waiting for the output register.
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= mmf_pkg::FP_ZERO;
            m_tlast  <= 1'b0;
            m_tuser  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mmf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_a (
    .clk   (clk),
    .we    (ram_a_we),
    .waddr (a_loaded[ADDR_W-1:0]),
    .wdata (fpu_result),
    .raddr (a_ptr),
    .rdata (ram_a_rdata)
  );

  mmf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_b (
    .clk   (clk),
    .we    (ram_b_we),
    .waddr (b_loaded[ADDR_W-1:0]),
    .wdata (fpu_result),
    .raddr (b_ptr),
    .rdata (ram_b_rdata)
  );

  mmf_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .req    (fpu_req),
    .a      (op_a),
    .b      (op_b),
    .done   (fpu_done),
    .result (fpu_result)
  );

`include "matrix_multiply_fp32_assert.svh"

  // A status-only reply never carries a value or the end-of-product mark.
  `MMF_ASSERT_IMP(a_status_reply, m_tvalid && m_tuser[0], m_tdata == 32'd0 && !m_tlast)
  // The arithmetic unit only finishes while the sequencer waits for it.
  `MMF_ASSERT_IMP(a_fpu_owner, fpu_done,
                  state == S_CVT || state == S_MUL || state == S_ADD)
  // Delivering the final element restarts both loads and the read position.
  `MMF_ASSERT_NXT(a_final_clear, out_load && final_read,
                  a_loaded == '0 && b_loaded == '0 && out_position == '0)
  // A load-A transfer that fits starts a conversion and closes the input.
  `MMF_ASSERT_NXT(a_load_busy, in_xfer && s_tuser == mmf_pkg::ACT_LOAD_A && a_room,
                  !s_tready)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the fp32 matrix multiplier.
`timescale 1ns / 1ps

module tb;

  // Action code that the block ignores; the package names only the used ones.
  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam int STORE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        status;
  } product_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] element
  logic [1:0]  s_tuser = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] value
  logic        m_tlast;
  logic [0:0]  m_tuser;        // [0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  matrix_multiply_fp32 u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block's registers, stores and counters.
  logic [4:0]  sh_rows, sh_inner, sh_cols;
  logic [1:0]  sh_fmt_a, sh_fmt_b;
  logic [31:0] a_mem [STORE_DEPTH];
  logic [31:0] b_mem [STORE_DEPTH];
  int unsigned a_count, b_count, c_pos;

  product_t pending_products[$];
  int errors = 0;
  int items_sent = 0;
  int products_seen = 0;
  int status_seen = 0;
  int cycles = 0;
  bit steady_send = 0;
  bit steady_recv = 0;

  // ---------------------------------------------------------------------
  // Floating-point helpers. A product of two fp32 values is exact in double
  // precision, and a sum of two fp32 values rounded to double and then to
  // fp32 gives the same result as a direct fp32 rounding, so double
  // arithmetic plus an explicit round-to-nearest-even step is faithful.
  // ---------------------------------------------------------------------
  function automatic real fp32_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({b[31], 11'h7FF, 52'd0});
    end
    if (b[30:23] == 8'd0) begin
      if (b[22:0] == 0) return $bitstoreal({b[31], 63'd0});
      // Subnormal: mantissa times 2^-149, both exact in double.
      r = real'(int'({9'd0, b[22:0]})) * $bitstoreal({1'b0, 11'd874, 52'd0});
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] real_to_fp32(real r);
    logic [63:0] d, sig, keep, rem, half;
    logic sgn;
    int ex, sh;
    d = $realtobits(r);
    sgn = d[63];
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 0) return mmf_pkg::FP_QNAN;
      return {sgn, 8'hFF, 23'd0};
    end
    if (d[62:52] == 11'd0) return {sgn, 31'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    ex = int'(d[62:52]) - 1023 + 127;
    sh = (ex >= 1) ? 29 : 30 - ex;
    if (sh > 60) return {sgn, 31'd0};
    keep = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    if (ex >= 1) begin
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        ex++;
      end
      if (ex >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(ex), keep[22:0]};
    end
    // A subnormal that rounds up to 2^23 lands on the smallest normal.
    return {sgn, keep[30:0]};
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [9:0] man;
    logic [10:0] norm;
    int ex;
    man = h[9:0];
    if (h[14:10] == 5'd0) begin
      if (man == 0) return {h[15], 31'd0};
      norm = {1'b0, man};
      ex = 113;
      while (!norm[10]) begin
        norm = norm << 1;
        ex--;
      end
      return {h[15], 8'(ex), norm[9:0], 13'd0};
    end
    if (h[14:10] == 5'd31) begin
      // Infinities stay infinite, NaNs get the quiet bit.
      return {h[15], 8'hFF, (man != 0), man[8:0], 13'd0};
    end
    return {h[15], 8'(int'(h[14:10]) + 112), man, 13'd0};
  endfunction

  function automatic logic [31:0] to_fp32(logic [1:0] fmt, logic [31:0] raw);
    logic [31:0] w;
    case (fmt)
      mmf_pkg::FMT_FP16: return widen_half(raw[15:0]);
      mmf_pkg::FMT_BF16: begin
        w = {raw[15:0], 16'd0};
        if (w[30:23] == 8'hFF && w[22:0] != 0) w[22] = 1'b1;
        return w;
      end
      mmf_pkg::FMT_INT32: return real_to_fp32(real'(int'(raw)));
      default: return raw;
    endcase
  endfunction

  function automatic int unsigned clamp_dim(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  // Advances the shadow state by one accepted input transfer and queues the
  // product element that a read produces.
  task automatic predict_transfer(logic [1:0] act, logic [31:0] raw);
    int unsigned m, k, n, row, col;
    real acc, term;
    product_t res;
    m = clamp_dim(sh_rows);
    k = clamp_dim(sh_inner);
    n = clamp_dim(sh_cols);
    case (act)
      mmf_pkg::ACT_LOAD_A: if (a_count < m * k) begin
        a_mem[a_count] = to_fp32(sh_fmt_a, raw);
        a_count++;
      end
      mmf_pkg::ACT_LOAD_B: if (b_count < k * n) begin
        b_mem[b_count] = to_fp32(sh_fmt_b, raw);
        b_count++;
      end
      mmf_pkg::ACT_READ: begin
        if (a_count < m * k || b_count < k * n || c_pos >= m * n) begin
          res = '{value: mmf_pkg::FP_ZERO, last: 1'b0, status: 1'b1};
        end else begin
          row = c_pos / n;
          col = c_pos % n;
          acc = 0.0;
          for (int p = 0; p < k; p++) begin
            term = fp32_to_real(real_to_fp32(fp32_to_real(a_mem[row * k + p]) *
                                             fp32_to_real(b_mem[p * n + col])));
            acc = fp32_to_real(real_to_fp32(acc + term));
          end
          c_pos++;
          res = '{value: real_to_fp32(acc), last: (c_pos >= m * n), status: 1'b0};
          if (res.last) begin
            a_count = 0;
            b_count = 0;
            c_pos = 0;
          end
        end
        pending_products.push_back(res);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus side.
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item and records what it should produce once it is accepted.
  task automatic send_item(logic [1:0] act, logic [31:0] raw);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = raw;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_transfer(act, raw);
    items_sent++;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Holds the input stream until every queued product has come back, then
  // allows for a load that may still be converting.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 5'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      mmf_pkg::REG_ROWS_A: sh_rows = val[4:0];
      mmf_pkg::REG_INNER: sh_inner = val[4:0];
      mmf_pkg::REG_COLS_B: sh_cols = val[4:0];
      mmf_pkg::REG_A_FORMAT: sh_fmt_a = val[1:0];
      mmf_pkg::REG_B_FORMAT: sh_fmt_b = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [4:0] m, logic [4:0] k, logic [4:0] n,
                           logic [1:0] fa, logic [1:0] fb);
    wait_drained();
    write_reg(mmf_pkg::REG_ROWS_A, 32'(m));
    write_reg(mmf_pkg::REG_INNER, 32'(k));
    write_reg(mmf_pkg::REG_COLS_B, 32'(n));
    write_reg(mmf_pkg::REG_A_FORMAT, 32'(fa));
    write_reg(mmf_pkg::REG_B_FORMAT, 32'(fb));
  endtask

  // Values of moderate size so that sums stay finite, with fully random bit
  // patterns for about half of the picks.
  function automatic logic [31:0] pick_element(logic [1:0] fmt);
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 1)) return r;
    case (fmt)
      mmf_pkg::FMT_FP32: return {r[31], 8'($urandom_range(110, 140)), r[22:0]};
      mmf_pkg::FMT_FP16: return {r[31:16], r[15], 5'($urandom_range(8, 22)), r[9:0]};
      mmf_pkg::FMT_BF16: return {r[31:16], r[15], 8'($urandom_range(115, 138)), r[6:0]};
      default: return 32'($urandom_range(0, 400)) - 32'd200;
    endcase
  endfunction

  // Directed: edge values in every format, early and late reads, extra loads,
  // and the ignored action.
  task automatic test_directed();
    logic [31:0] edge_a[4] = '{32'h7F7F_FFFF, 32'h8000_0001, 32'h7F80_0000, 32'h3F80_0000};
    logic [31:0] edge_b[4] = '{32'h4000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000};
    set_shape(5'd2, 5'd2, 5'd2, mmf_pkg::FMT_FP32, mmf_pkg::FMT_FP32);
    send_item(mmf_pkg::ACT_READ, 32'hFFFF_FFFF);      // too early
    foreach (edge_a[i]) send_item(mmf_pkg::ACT_LOAD_A, edge_a[i]);
    send_item(mmf_pkg::ACT_LOAD_A, 32'h1234_5678);    // beyond the size of A
    send_item(ACT_IDLE, 32'hFFFF_FFFF);
    foreach (edge_b[i]) send_item(mmf_pkg::ACT_LOAD_B, edge_b[i]);
    repeat (4) send_item(mmf_pkg::ACT_READ, '0);
    send_item(mmf_pkg::ACT_READ, '0);                 // counters were cleared

    // fp16 and bf16 specials: subnormal, infinity, signaling NaN, largest.
    set_shape(5'd1, 5'd2, 5'd1, mmf_pkg::FMT_FP16, mmf_pkg::FMT_BF16);
    send_item(mmf_pkg::ACT_LOAD_A, 32'hFFFF_0001);
    send_item(mmf_pkg::ACT_LOAD_A, 32'h0000_7C00);
    send_item(mmf_pkg::ACT_LOAD_B, 32'h0000_7F81);
    send_item(mmf_pkg::ACT_LOAD_B, 32'hFFFF_7F7F);
    send_item(mmf_pkg::ACT_READ, '0);
    set_shape(5'd1, 5'd2, 5'd1, mmf_pkg::FMT_INT32, mmf_pkg::FMT_FP16);
    send_item(mmf_pkg::ACT_LOAD_A, 32'h8000_0000);
    send_item(mmf_pkg::ACT_LOAD_A, 32'h7FFF_FFFF);
    send_item(mmf_pkg::ACT_LOAD_B, 32'h0000_7BFF);
    send_item(mmf_pkg::ACT_LOAD_B, 32'h0000_7E01);
    send_item(mmf_pkg::ACT_READ, '0);
  endtask

  // Runs one shape; the limit test gives it zero, too large and full inner sizes.
  task automatic run_shape(logic [4:0] m, logic [4:0] k, logic [4:0] n,
                           logic [1:0] fa, logic [1:0] fb, bit cut);
    int unsigned sa, sb, sc, stop_at, done;
    set_shape(m, k, n, fa, fb);
    sa = clamp_dim(m) * clamp_dim(k);
    sb = clamp_dim(k) * clamp_dim(n);
    sc = clamp_dim(m) * clamp_dim(n);
    stop_at = cut ? $urandom_range(1, sa + sb + sc) : sa + sb + sc + 1;
    done = 0;
    for (int i = 0; i < sa + sb + sc && done < stop_at; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        send_item(2'($urandom_range(0, 3)), $urandom);
      end
      if (i < sa) send_item(mmf_pkg::ACT_LOAD_A, pick_element(fa));
      else if (i < sa + sb) send_item(mmf_pkg::ACT_LOAD_B, pick_element(fb));
      else send_item(mmf_pkg::ACT_READ, $urandom);
      done++;
    end
  endtask

  task automatic test_dimension_limits();
    run_shape(5'd31, 5'd0, 5'd1, mmf_pkg::FMT_FP32, mmf_pkg::FMT_BF16, 0);
    run_shape(5'd1, 5'd16, 5'd1, mmf_pkg::FMT_BF16, mmf_pkg::FMT_INT32, 0);
    run_shape(5'd1, 5'd1, 5'd17, mmf_pkg::FMT_FP16, mmf_pkg::FMT_FP32, 0);
  endtask

  // Back-to-back transfers with no stalls, then a pause until all is back.
  task automatic test_full_rate();
    steady_send = 1;
    steady_recv = 1;
    run_shape(5'd3, 5'd2, 5'd3, mmf_pkg::FMT_FP32, mmf_pkg::FMT_FP32, 0);
    wait_drained();
    steady_send = 0;
    steady_recv = 0;
  endtask

  task automatic test_random(int target);
    logic [4:0] dims[3];
    int big;
    while (items_sent < target) begin
      foreach (dims[i]) dims[i] = 5'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) begin
        big = $urandom_range(0, 2);
        dims[big] = 5'($urandom_range(9, 16));
      end
      if ($urandom_range(0, 19) == 0) begin
        dims[$urandom_range(0, 2)] = 5'($urandom_range(0, 1) ? 0 : 31);
      end
      run_shape(dims[0], dims[1], dims[2], 2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), $urandom_range(0, 99) < 15);
      steady_send = ($urandom_range(0, 7) == 0);
      steady_recv = ($urandom_range(0, 7) == 0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (steady_recv) begin
      m_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: m_tready <= 1'b0;
        1: m_tready <= ($urandom_range(0, 9) == 0);
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    product_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: product with nothing expected: value %h last %b status %b",
                 $time, m_tdata, m_tlast, m_tuser[0]);
        errors++;
      end else begin
        want = pending_products.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
          errors++;
        end
        if (m_tuser[0] !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, m_tuser[0]);
          errors++;
        end
        if (want.status) status_seen++;
        else products_seen++;
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    sh_rows = 5'd16;
    sh_inner = 5'd16;
    sh_cols = 5'd16;
    sh_fmt_a = mmf_pkg::FMT_FP32;
    sh_fmt_b = mmf_pkg::FMT_FP32;
    a_count = 0;
    b_count = 0;
    c_pos = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_dimension_limits();
    test_full_rate();
    test_random(1350);

    wait_drained();
    $display("Sent %0d transfers; checked %0d product elements and %0d empty reads.",
             items_sent, products_seen, status_seen);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
